// ----- design/fbps_pkg.sv -----
// Shared constants for the flow bucket packet sampler.
package fbps_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned SkipW  = 17;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned BktW   = 12;
  localparam int unsigned HashW  = 64;
  localparam int unsigned RndW   = 31;
  localparam int unsigned ProtoW = 8;

  localparam logic [ProtoW-1:0] PROTO_TCP = 8'd6;
  localparam logic [ProtoW-1:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] REG_PREFIX = 2'd0;
  localparam logic [1:0] REG_WRAP   = 2'd1;
  localparam logic [1:0] REG_RATE   = 2'd2;
  localparam logic [1:0] REG_SIZE   = 2'd3;

  localparam logic [CntW-1:0]  PREFIX_RST = 16'd1;
  localparam logic [CntW-1:0]  WRAP_RST   = 16'd16;
  localparam logic [CntW-1:0]  RATE_RST   = 16'd100;
  localparam logic [SizeW-1:0] SIZE_RST   = 13'd4096;

  localparam logic [6:0] HASH_STEPS = 7'd64;
  localparam logic [6:0] RND_STEPS  = 7'd31;

endpackage

// ----- design/flow_bucket_packet_sampler_core.sv -----
// Flow bucket packet sampler: top level with counter table and shared divider.
//
// Usage: packets enter on the s_axis beat (protocol, flow hash, random word);
// one result beat per packet leaves on m_axis (sampled flag on tuser, weight
// and bucket index on tdata). Settings are written over the APB port while
// the block is idle.
// Only TCP/UDP packets with a nonzero hash touch state. Such a packet runs
// through a restoring divider (hash mod table size, one bit a cycle), then
// through the counter table read and update states; a sampled packet makes
// a further divider pass for the new skip. One packet is in flight at a
// time; s_axis_tready is high only when the sequencer is idle.
// After reset the counter table is swept to zero, one entry a cycle, with
// s_axis_tready low. A stalled receiver holds the result register; the next
// packet may still be taken and worked on, and waits to be pushed until the
// register frees.
module flow_bucket_packet_sampler_core #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // protocol[7:0], flow_hash[71:8], random_word[102:72]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // sample_weight[16:0], bucket_index[28:17]
  output logic         m_axis_tuser,  // sampled
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import fbps_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0]    LastAddr = AW'(TABLE_DEPTH - 1);
  localparam logic [SkipW-1:0] DepthW   = SkipW'(TABLE_DEPTH);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  // configuration
  logic [CntW-1:0]  prefix_q, wrap_q, rate_q;
  logic [SizeW-1:0] size_q;
  logic             cfg_we;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= PREFIX_RST;
      wrap_q   <= WRAP_RST;
      rate_q   <= RATE_RST;
      size_q   <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PREFIX: prefix_q <= pwdata[CntW-1:0];
        REG_WRAP:   wrap_q   <= pwdata[CntW-1:0];
        REG_RATE:   rate_q   <= pwdata[CntW-1:0];
        REG_SIZE:   size_q   <= pwdata[SizeW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PREFIX: prdata = 32'(prefix_q);
      REG_WRAP:   prdata = 32'(wrap_q);
      REG_RATE:   prdata = 32'(rate_q);
      REG_SIZE:   prdata = 32'(size_q);
      default:    prdata = '0;
    endcase
  end

  // divisors
  logic [SkipW-1:0] size_ext, eff_size, rate2, skip_mod;

  always_comb begin
    size_ext = (size_q == '0) ? SkipW'(1) : SkipW'(size_q);
    eff_size = (size_ext > DepthW) ? DepthW : size_ext;
    rate2    = {rate_q, 1'b0};
    skip_mod = (rate2 > SkipW'(1)) ? rate2 - SkipW'(1) : SkipW'(1);
  end

  // sequencer state
  logic [2:0]       st_q, st_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [HashW-1:0] dvd_q, dvd_d;
  logic [SkipW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [6:0]       cnt_q, cnt_d;
  logic             sel_q, sel_d;
  logic [RndW-1:0]  rnd_q, rnd_d;
  logic [SkipW-1:0] prog_q, prog_d, skip_q, skip_d;
  logic             res_smp_q, res_smp_d;
  logic [SkipW-1:0] res_wgt_q, res_wgt_d;
  logic [BktW-1:0]  res_bkt_q, res_bkt_d;
  logic             out_v_q, out_v_d;
  logic             out_smp_q;
  logic [SkipW-1:0] out_wgt_q;
  logic [BktW-1:0]  out_bkt_q;
  logic             out_load;

  // memory
  logic [CntW-1:0] mem [TABLE_DEPTH];
  logic [CntW-1:0] rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [CntW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rem_q[AW-1:0]];
  end

  // shared divider step
  logic [SkipW:0]   rem_sh;
  logic             div_ge;
  logic [SkipW-1:0] rem_nx;

  always_comb begin
    rem_sh = {rem_q, dvd_q[HashW-1]};
    div_ge = rem_sh >= {1'b0, dvs_q};
    rem_nx = div_ge ? SkipW'(rem_sh - {1'b0, dvs_q}) : rem_sh[SkipW-1:0];
  end

  // input fields
  logic [ProtoW-1:0] in_proto;
  logic [HashW-1:0]  in_hash;
  logic [RndW-1:0]   in_rnd;
  logic              in_ok;

  assign in_proto = s_axis_tdata[7:0];
  assign in_hash  = s_axis_tdata[71:8];
  assign in_rnd   = s_axis_tdata[102:72];
  assign in_ok    = ((in_proto == PROTO_TCP) || (in_proto == PROTO_UDP)) && (in_hash != '0);

  assign s_axis_tready = (st_q == ST_IDLE);
  assign out_load      = (st_q == ST_PUSH) && (!out_v_q || m_axis_tready);

  // counter update
  logic [CntW:0]    cnt_inc;
  logic [SkipW-1:0] prog_inc;

  assign cnt_inc  = {1'b0, rd_q} + (CntW+1)'(1);
  assign prog_inc = prog_q + SkipW'(1);

  always_comb begin
    st_d      = st_q;
    clr_d     = clr_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    cnt_d     = cnt_q;
    sel_d     = sel_q;
    rnd_d     = rnd_q;
    prog_d    = prog_q;
    skip_d    = skip_q;
    res_smp_d = res_smp_q;
    res_wgt_d = res_wgt_q;
    res_bkt_d = res_bkt_q;
    mem_we    = 1'b0;
    mem_waddr = rem_q[AW-1:0];
    mem_wdata = '0;

    unique case (st_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_smp_d = 1'b0;
          res_wgt_d = '0;
          res_bkt_d = '0;
          rnd_d     = in_rnd;
          dvd_d     = in_hash;
          rem_d     = '0;
          dvs_d     = eff_size;
          cnt_d     = HASH_STEPS;
          sel_d     = 1'b0;
          st_d      = in_ok ? ST_DIV : ST_PUSH;
        end
      end
      ST_DIV: begin
        rem_d = rem_nx;
        dvd_d = {dvd_q[HashW-2:0], 1'b0};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          if (sel_q) begin
            skip_d = rem_nx + SkipW'(1);
            st_d   = ST_PUSH;
          end else begin
            st_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        st_d = ST_UPD;
      end
      ST_UPD: begin
        res_bkt_d = rem_q[BktW-1:0];
        mem_we    = 1'b1;
        st_d      = ST_PUSH;
        if (cnt_inc > {1'b0, wrap_q}) begin
          mem_wdata = '0;
        end else begin
          mem_wdata = cnt_inc[CntW-1:0];
          if (cnt_inc < {1'b0, prefix_q}) begin
            prog_d = prog_inc;
            if (prog_inc == skip_q) begin
              res_smp_d = 1'b1;
              res_wgt_d = skip_q;
              prog_d    = '0;
              dvd_d     = {rnd_q, {(HashW-RndW){1'b0}}};
              rem_d     = '0;
              dvs_d     = skip_mod;
              cnt_d     = RND_STEPS;
              sel_d     = 1'b1;
              st_d      = ST_DIV;
            end
          end
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
    if (out_load) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
      prog_q  <= '0;
      skip_q  <= SkipW'(1);
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      prog_q  <= prog_d;
      skip_q  <= skip_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    rnd_q     <= rnd_d;
    res_smp_q <= res_smp_d;
    res_wgt_q <= res_wgt_d;
    res_bkt_q <= res_bkt_d;
    if (out_load) begin
      out_smp_q <= res_smp_q;
      out_wgt_q <= res_wgt_q;
      out_bkt_q <= res_bkt_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_smp_q;
  assign m_axis_tdata  = {3'b000, out_bkt_q, out_wgt_q};

endmodule
